// ===== rtl/kalman_filter_pos_vel_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef KALMAN_FILTER_POS_VEL_CORE_DEFINES_SVH
`define KALMAN_FILTER_POS_VEL_CORE_DEFINES_SVH

// consequent in the cycle after the antecedent
`define KFPV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kfpv check failed");

// consequent in the same cycle as the antecedent
`define KFPV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kfpv check failed");

`endif

// ===== rtl/kfpv_pkg.sv =====
package kfpv_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic CFG_SMOOTHING = 1'b0;
  localparam logic CFG_TIME_STEP = 1'b1;

  typedef enum logic [4:0] {
    S_ZERO, S_ONE, S_X0, S_X1, S_P0, S_P1, S_P2, S_P3, S_PREV, S_Z, S_ZV, S_XP,
    S_PA, S_P00, S_P01, S_P10, S_P11, S_S00, S_S11, S_DT, S_R,
    S_N0, S_N1, S_N2, S_N3, S_K0, S_K1, S_K2, S_K3, S_Y0, S_Y1
  } src_t;

  typedef enum logic [3:0] {
    U_INIT, U_DIV, U_BASE, U_ADD, U_SUB, U_MUL, U_ACCP, U_ACCN,
    U_RAWP, U_RAWN, U_SAT, U_DET, U_FIN
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t kind;
    src_t      a;
    src_t      b;
    src_t      dst;     // S_ZERO: no write
    logic      den_det; // divide by determinant, else by time step
  } uop_t;

  typedef struct packed {
    logic load;
    logic en;
    logic start;
    logic cap;
    uop_t uop;
  } ctrl_cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIVW, ST_DONE} ctrl_state_t;

  localparam int PROG_LEN = 110;
  localparam int STEP_W   = $clog2(PROG_LEN);

  function automatic uop_t uo(uop_kind_t k, src_t a, src_t b, src_t d, logic dd);
    uop_t u;
    u.kind    = k;
    u.a       = a;
    u.b       = b;
    u.dst     = d;
    u.den_det = dd;
    return u;
  endfunction

  // update microprogram: predict, gain, correct
  localparam uop_t PROG [PROG_LEN] = '{
    uo(U_INIT, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_DIV,  S_Z,    S_PREV, S_ZV,   1'b0),
    // predicted position
    uo(U_BASE, S_X0,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_DT,   S_X1,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_XP,   1'b0),
    // predicted covariance
    uo(U_BASE, S_P0,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_DT,   S_P2,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_PA,   1'b0),
    uo(U_BASE, S_P1,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_DT,   S_P3,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P01,  1'b0),
    uo(U_BASE, S_PA,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P01,  S_DT,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_ADD,  S_ONE,  S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P00,  1'b0),
    uo(U_BASE, S_P2,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P3,   S_DT,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P10,  1'b0),
    uo(U_BASE, S_P3,   S_ZERO, S_ZERO, 1'b0),
    uo(U_ADD,  S_ONE,  S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P11,  1'b0),
    // innovation covariance diagonal
    uo(U_BASE, S_P00,  S_ZERO, S_ZERO, 1'b0),
    uo(U_ADD,  S_R,    S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_S00,  1'b0),
    uo(U_BASE, S_P11,  S_ZERO, S_ZERO, 1'b0),
    uo(U_ADD,  S_R,    S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_S11,  1'b0),
    // determinant
    uo(U_BASE, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_S00,  S_S11,  S_ZERO, 1'b0),
    uo(U_RAWP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P01,  S_P10,  S_ZERO, 1'b0),
    uo(U_RAWN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_DET,  S_ZERO, S_ZERO, S_ZERO, 1'b0),
    // gain numerators
    uo(U_BASE, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P00,  S_S11,  S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P01,  S_P10,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_N0,   1'b0),
    uo(U_BASE, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P01,  S_S00,  S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P00,  S_P01,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_N1,   1'b0),
    uo(U_BASE, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P10,  S_S11,  S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P11,  S_P10,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_N2,   1'b0),
    uo(U_BASE, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P11,  S_S00,  S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_P10,  S_P01,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_N3,   1'b0),
    // gains
    uo(U_DIV,  S_N0,   S_ZERO, S_K0,   1'b1),
    uo(U_DIV,  S_N1,   S_ZERO, S_K1,   1'b1),
    uo(U_DIV,  S_N2,   S_ZERO, S_K2,   1'b1),
    uo(U_DIV,  S_N3,   S_ZERO, S_K3,   1'b1),
    // innovation
    uo(U_BASE, S_Z,    S_ZERO, S_ZERO, 1'b0),
    uo(U_SUB,  S_XP,   S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_Y0,   1'b0),
    uo(U_BASE, S_ZV,   S_ZERO, S_ZERO, 1'b0),
    uo(U_SUB,  S_X1,   S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_Y1,   1'b0),
    // corrected state
    uo(U_BASE, S_XP,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K0,   S_Y0,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K1,   S_Y1,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_X0,   1'b0),
    uo(U_BASE, S_X1,   S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K2,   S_Y0,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K3,   S_Y1,   S_ZERO, 1'b0),
    uo(U_ACCP, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_X1,   1'b0),
    // corrected covariance
    uo(U_BASE, S_P00,  S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K0,   S_P00,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K1,   S_P10,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P0,   1'b0),
    uo(U_BASE, S_P01,  S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K0,   S_P01,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K1,   S_P11,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P1,   1'b0),
    uo(U_BASE, S_P10,  S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K2,   S_P00,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K3,   S_P10,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P2,   1'b0),
    uo(U_BASE, S_P11,  S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K2,   S_P01,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_MUL,  S_K3,   S_P11,  S_ZERO, 1'b0),
    uo(U_ACCN, S_ZERO, S_ZERO, S_ZERO, 1'b0),
    uo(U_SAT,  S_ZERO, S_ZERO, S_P3,   1'b0),
    uo(U_FIN,  S_ZERO, S_ZERO, S_ZERO, 1'b0)
  };

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/kfpv_ctrl.sv =====
module kfpv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                div_done,
  output kfpv_pkg::ctrl_cmd_t cmd
);
  import kfpv_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  uop_t              cur;

  assign cur       = PROG[step_r];
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.uop       = cur;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = (in_op == OP_UPDATE) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        cmd.en = 1'b1;
        if (cur.kind == U_DIV) begin
          cmd.start = 1'b1;
          state_nxt = ST_DIVW;
        end else if (cur.kind == U_FIN) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_DONE: begin
        // result register frees up when its beat goes out
        if (!out_valid_r || !out_stall) begin
          cmd.cap       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/kfpv_div.sv =====
module kfpv_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [FRAC_BITS+33:0] num,
  input  logic signed [63:0]          den,
  output logic                        done,
  output logic signed [FRAC_BITS+33:0] quot
);
  localparam int NUM_W = FRAC_BITS + 34;
  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W);

  logic [MAG_W-1:0] q_r;
  logic [63:0]      rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, neg_r;
  logic [NUM_W-1:0] num_abs;
  logic [64:0]      rem_sh;
  logic [65:0]      diff;

  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rem_sh  = {rem_r, q_r[MAG_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, den_r};
  assign done    = done_r;
  assign quot    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(MAG_W - 1));
      if (start) busy_r <= 1'b1;
      else if (busy_r && (cnt_r == CNT_W'(MAG_W - 1))) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num_abs[MAG_W-1:0];
      rem_r <= '0;
      den_r <= den[63] ? 64'(-den) : 64'(den);
      neg_r <= num[NUM_W-1] ^ den[63];
      cnt_r <= '0;
    end else if (busy_r) begin
      if (!diff[65]) begin
        rem_r <= diff[63:0];
        q_r   <= {q_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[63:0];
        q_r   <= {q_r[MAG_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ===== rtl/kfpv_dpath.sv =====
module kfpv_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kfpv_pkg::ctrl_cmd_t cmd,
  output logic                div_done,
  input  logic [1:0]          in_op,
  input  logic signed [31:0]  in_position_in,
  input  logic signed [31:0]  in_velocity_in,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_data,
  output logic signed [31:0]  out_position_est,
  output logic signed [31:0]  out_velocity_est,
  output logic [30:0]         out_position_variance,
  output logic [30:0]         out_velocity_variance
);
  import kfpv_pkg::*;

  localparam int NUM_W  = FRAC_BITS + 34;
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam int R_BIAS = (ONE_I + 500) / 1000;

  logic [19:0]        smooth_r;
  logic [16:0]        tstep_r;
  logic signed [31:0] x0_r, x1_r, p0_r, p1_r, p2_r, p3_r, prev_r;
  logic signed [31:0] z_r, zv_r, xp_r, pa_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] s00_r, s11_r, dt_r, r_r;
  logic signed [31:0] n0_r, n1_r, n2_r, n3_r, k0_r, k1_r, k2_r, k3_r, y0_r, y1_r;
  logic signed [63:0] det_r, prod_r;
  logic signed [65:0] acc_r;

  logic signed [31:0] a_val, b_val, wr_val;
  logic               wr_en;
  logic signed [63:0] mul_res, prod_sc, det_sc;
  logic signed [65:0] acc_nxt;
  logic signed [32:0] diff33;
  logic signed [NUM_W-1:0] div_num, div_quot;
  logic signed [63:0] div_den;
  uop_t               u;

  assign u         = cmd.uop;
  assign cfg_ready = 1'b1;

  function automatic logic signed [31:0] pick(src_t s);
    logic signed [31:0] v;
    unique case (s)
      S_ZERO: v = '0;
      S_ONE:  v = 32'(ONE_I);
      S_X0:   v = x0_r;
      S_X1:   v = x1_r;
      S_P0:   v = p0_r;
      S_P1:   v = p1_r;
      S_P2:   v = p2_r;
      S_P3:   v = p3_r;
      S_PREV: v = prev_r;
      S_Z:    v = z_r;
      S_ZV:   v = zv_r;
      S_XP:   v = xp_r;
      S_PA:   v = pa_r;
      S_P00:  v = p00_r;
      S_P01:  v = p01_r;
      S_P10:  v = p10_r;
      S_P11:  v = p11_r;
      S_S00:  v = s00_r;
      S_S11:  v = s11_r;
      S_DT:   v = dt_r;
      S_R:    v = r_r;
      S_N0:   v = n0_r;
      S_N1:   v = n1_r;
      S_N2:   v = n2_r;
      S_N3:   v = n3_r;
      S_K0:   v = k0_r;
      S_K1:   v = k1_r;
      S_K2:   v = k2_r;
      S_K3:   v = k3_r;
      S_Y0:   v = y0_r;
      S_Y1:   v = y1_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    a_val = pick(u.a);
    b_val = pick(u.b);
  end

  assign mul_res = a_val * b_val;
  // scale by 2^-FRAC_BITS, truncating toward zero
  assign prod_sc = (prod_r + (prod_r[63] ? 64'(ONE_I - 1) : 64'sd0)) >>> FRAC_BITS;
  assign det_sc  = 64'((acc_r + (acc_r[65] ? 66'(ONE_I - 1) : 66'sd0)) >>> FRAC_BITS);

  assign diff33  = {a_val[31], a_val} - {b_val[31], b_val};
  assign div_num = NUM_W'(diff33) <<< FRAC_BITS;
  assign div_den = u.den_det ? det_r : 64'(dt_r);

  kfpv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    acc_nxt = acc_r;
    wr_en   = 1'b0;
    wr_val  = sat32(acc_r);
    if (cmd.en) begin
      case (u.kind)
        U_BASE: acc_nxt = 66'(a_val);
        U_ADD:  acc_nxt = acc_r + 66'(a_val);
        U_SUB:  acc_nxt = acc_r - 66'(a_val);
        U_ACCP: acc_nxt = acc_r + 66'(prod_sc);
        U_ACCN: acc_nxt = acc_r - 66'(prod_sc);
        U_RAWP: acc_nxt = acc_r + 66'(prod_r);
        U_RAWN: acc_nxt = acc_r - 66'(prod_r);
        U_SAT: begin
          acc_nxt = 66'(sat32(acc_r));
          wr_en   = 1'b1;
        end
        default: acc_nxt = acc_r;
      endcase
    end
    if (div_done && u.kind == U_DIV) begin
      wr_en  = 1'b1;
      // singular innovation covariance gives zero gain
      wr_val = (u.den_det && det_r == 64'sd0) ? 32'sd0 : sat32(66'(div_quot));
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.en && u.kind == U_MUL) prod_r <= mul_res;
    if (cmd.en && u.kind == U_DET) det_r <= det_sc;
    if (cmd.en && u.kind == U_INIT) begin
      dt_r <= (tstep_r == 17'd0) ? 32'sd1 : 32'($unsigned(tstep_r));
      r_r  <= sat32(66'($unsigned(smooth_r)) * 66'sd100 + 66'(R_BIAS));
    end
    if (cmd.load) z_r <= in_position_in;
    if (wr_en) begin
      unique case (u.dst)
        S_ZV:  zv_r  <= wr_val;
        S_XP:  xp_r  <= wr_val;
        S_PA:  pa_r  <= wr_val;
        S_P00: p00_r <= wr_val;
        S_P01: p01_r <= wr_val;
        S_P10: p10_r <= wr_val;
        S_P11: p11_r <= wr_val;
        S_S00: s00_r <= wr_val;
        S_S11: s11_r <= wr_val;
        S_N0:  n0_r  <= wr_val;
        S_N1:  n1_r  <= wr_val;
        S_N2:  n2_r  <= wr_val;
        S_N3:  n3_r  <= wr_val;
        S_K0:  k0_r  <= wr_val;
        S_K1:  k1_r  <= wr_val;
        S_K2:  k2_r  <= wr_val;
        S_K3:  k3_r  <= wr_val;
        S_Y0:  y0_r  <= wr_val;
        S_Y1:  y1_r  <= wr_val;
        default: ;
      endcase
    end
    if (cmd.cap) begin
      out_position_est      <= x0_r;
      out_velocity_est      <= x1_r;
      out_position_variance <= p0_r[31] ? 31'd0 : p0_r[30:0];
      out_velocity_variance <= p3_r[31] ? 31'd0 : p3_r[30:0];
    end
  end

  // architectural state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 20'd19661;
      tstep_r  <= 17'd655;
      x0_r     <= '0;
      x1_r     <= '0;
      p0_r     <= 32'(ONE_I);
      p1_r     <= '0;
      p2_r     <= '0;
      p3_r     <= 32'(ONE_I);
      prev_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SMOOTHING: smooth_r <= cfg_data;
          CFG_TIME_STEP: tstep_r  <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (cmd.load && in_op == OP_SET) begin
        x0_r   <= in_position_in;
        x1_r   <= in_velocity_in;
        prev_r <= in_position_in;
      end
      if (cmd.load && in_op == OP_CLEAR) begin
        p0_r <= '0;
        p1_r <= '0;
        p2_r <= '0;
        p3_r <= '0;
      end
      if (wr_en) begin
        unique case (u.dst)
          S_X0: x0_r <= wr_val;
          S_X1: x1_r <= wr_val;
          S_P0: p0_r <= wr_val;
          S_P1: p1_r <= wr_val;
          S_P2: p2_r <= wr_val;
          S_P3: p3_r <= wr_val;
          default: ;
        endcase
      end
      if (cmd.en && u.kind == U_FIN) prev_r <= z_r;
    end
  end

endmodule

// ===== rtl/kalman_filter_pos_vel_core.sv =====
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    in_op, in_position_in, in_velocity_in
// out      output     out_valid/out_stall  out_position_est, out_velocity_est, variances
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An update runs a 110-step microprogram on one shared 32x32 multiplier and a
// radix-2 divider: 105 plain steps plus five divisions. out_valid rises in the same
// cycle that in_stall falls, so the next beat can be taken in that cycle.
// Set state, clear covariance and op 3 skip the microprogram: the beat is loaded
// in the idle state, then the result is captured from the done state.
// One item in flight; the next beat is taken once the result is in the output
// register, which holds while out_stall is high. Reset is synchronous, active low.
module kalman_filter_pos_vel_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_position_in,
  input  logic signed [31:0] in_velocity_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_position_est,
  output logic signed [31:0] out_velocity_est,
  output logic [30:0]        out_position_variance,
  output logic [30:0]        out_velocity_variance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_data
);
  import kfpv_pkg::*;

  ctrl_cmd_t cmd;
  logic      div_done;

  kfpv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  kfpv_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .div_done              (div_done),
    .in_op                 (in_op),
    .in_position_in        (in_position_in),
    .in_velocity_in        (in_velocity_in),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_position_est      (out_position_est),
    .out_velocity_est      (out_velocity_est),
    .out_position_variance (out_position_variance),
    .out_velocity_variance (out_velocity_variance)
  );

endmodule

// ===== rtl/kfpv_checker.sv =====
`include "kalman_filter_pos_vel_core_defines.svh"

module kfpv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_op,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_position_est,
  input logic [30:0]        out_position_variance,
  input logic [30:0]        out_velocity_variance
);
  import kfpv_pkg::*;

  `KFPV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_position_est))
  `KFPV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // clear beat taken on an empty output: the result shows up once the done state has captured it
  `KFPV_ASSERT_NEXT(a_clear_zeroes, $past(rst_n && in_valid && !in_stall && in_op == OP_CLEAR && !out_valid), out_valid && out_position_variance == 31'd0 && out_velocity_variance == 31'd0)
  `KFPV_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind kalman_filter_pos_vel_core kfpv_checker u_kfpv_checker (.*);
